[sv/psc_pkg.sv]
// Shared types and constants for the pitch shift comb voice block.
`default_nettype none
package psc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMB_DELAY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMB_GAIN  = 2'd3;

  // Shared multiplier operand selects.
  localparam logic [1:0] MOP_DLY  = 2'd0;  // phase * window length
  localparam logic [1:0] MOP_FRAC = 2'd1;  // frac * (b - a)
  localparam logic [1:0] MOP_WIN  = 2'd2;  // tap * window weight
  localparam logic [1:0] MOP_COMB = 2'd3;  // history * comb gain

  typedef struct packed {
    logic       accept;
    logic [1:0] mul_op;
    logic       tap2;
    logic       addr_ld;
    logic       rd_i0;
    logic       rd_i1;
    logic       cap_a;
    logic       tap_ld;
    logic       acc_tap;
    logic       acc_comb;
    logic       rd_hist;
    logic       finish;
  } psc_cmd_t;

endpackage
`default_nettype wire

[sv/psc_stream_if.sv]
// Valid/ready channel interfaces for input and result samples.
`default_nettype none
interface psc_in_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  in_sample;
  modport source (output valid, output in_sample, input ready);
  modport sink (input valid, input in_sample, output ready);
endinterface

interface psc_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  out_sample;
  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface
`default_nettype wire

[sv/pitch_shift_comb_voice_core.sv]
// Top level of the pitch shift comb voice: controller plus datapath.
// Usage:
//   in_chan   valid/ready channel, one signed 16-bit sample per beat.
//   out_chan  valid/ready channel, one saturated signed 16-bit sample per
//             input beat, in order.
//   cfg_*     write port: cfg_we with cfg_index 0 phase_step, 1 window_length,
//             2 comb_delay, 3 comb_gain; write only while the block is idle.
// Sequencing: one sample is worked at a time; a new beat can be taken in the
//   cycle after the result is loaded. The pace is set by the one shared
//   multiplier (seven products in turn) and the single read port of the
//   delay memory (four tap reads).
// Reset (rst_n low, synchronous): registers go to their defaults, pointers and
//   phase clear; the memories are not swept - fill tracking makes entries
//   never written read as zero, so the block is ready right after reset.
// Stall: the result sits in an output register; a new input beat is still
//   taken, and its result waits in the last step until out_chan drains.
`default_nettype none
module pitch_shift_comb_voice_core #(
  parameter int DELAY_DEPTH   = 4096,
  parameter int HISTORY_DEPTH = 256,
  parameter int PHASE_BITS    = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  psc_in_if.sink                               in_chan,
  psc_out_if.source                            out_chan,
  input  wire logic                            cfg_we,
  input  wire logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [psc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import psc_pkg::*;

  psc_cmd_t cmd;

  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  psc_datapath #(
    .DELAY_DEPTH   (DELAY_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .PHASE_BITS    (PHASE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .in_sample  (in_chan.in_sample),
    .out_sample (out_chan.out_sample)
  );

endmodule
`default_nettype wire

[sv/psc_ctrl.sv]
// Sequencer for the pitch shift comb voice: walks both taps and the comb term.
`default_nettype none
module psc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output psc_pkg::psc_cmd_t    cmd
);
  import psc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MD   = 4'd1;
  localparam logic [3:0] S_AD   = 4'd2;
  localparam logic [3:0] S_RA   = 4'd3;
  localparam logic [3:0] S_RB   = 4'd4;
  localparam logic [3:0] S_MF   = 4'd5;
  localparam logic [3:0] S_ST   = 4'd6;
  localparam logic [3:0] S_MW   = 4'd7;
  localparam logic [3:0] S_AC   = 4'd8;
  localparam logic [3:0] S_RH   = 4'd9;
  localparam logic [3:0] S_HA   = 4'd10;
  localparam logic [3:0] S_HC   = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       tap2_r, tap2_nxt;
  logic       ovld_r, ovld_nxt;
  logic       can_finish;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = ovld_r;
  assign can_finish = !ovld_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    tap2_nxt     = tap2_r;
    ovld_nxt     = ovld_r;
    cmd          = '0;
    cmd.tap2     = tap2_r;
    cmd.mul_op   = MOP_DLY;
    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          tap2_nxt   = 1'b0;
          state_nxt  = S_MD;
        end
      end
      S_MD: begin
        cmd.mul_op = MOP_DLY;
        state_nxt  = S_AD;
      end
      S_AD: begin
        cmd.addr_ld = 1'b1;
        state_nxt   = S_RA;
      end
      S_RA: begin
        cmd.rd_i0 = 1'b1;
        state_nxt = S_RB;
      end
      S_RB: begin
        cmd.rd_i1 = 1'b1;
        cmd.cap_a = 1'b1;
        state_nxt = S_MF;
      end
      S_MF: begin
        cmd.mul_op = MOP_FRAC;
        state_nxt  = S_ST;
      end
      S_ST: begin
        cmd.tap_ld = 1'b1;
        state_nxt  = S_MW;
      end
      S_MW: begin
        cmd.mul_op = MOP_WIN;
        state_nxt  = S_AC;
      end
      S_AC: begin
        cmd.acc_tap = 1'b1;
        if (tap2_r) begin
          state_nxt = S_RH;
        end else begin
          tap2_nxt  = 1'b1;
          state_nxt = S_MD;
        end
      end
      S_RH: begin
        cmd.rd_hist = 1'b1;
        state_nxt   = S_HA;
      end
      S_HA: begin
        cmd.mul_op = MOP_COMB;
        state_nxt  = S_HC;
      end
      S_HC: begin
        cmd.acc_comb = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (can_finish) begin
          cmd.finish = 1'b1;
          ovld_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap2_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap2_r  <= tap2_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

`ifndef SYNTHESIS
  a_finish_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!ovld_r || out_ready))
    else $error("result overwritten while previous beat pending");
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_MD) && !tap2_r)
    else $error("sample accept did not start first tap");
  a_second_tap_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AC) && tap2_r |=> (state_r == S_RH))
    else $error("second tap did not lead to comb read");
`endif
endmodule
`default_nettype wire

[sv/psc_datapath.sv]
// Datapath: config registers, delay and history memories, shared multiplier, accumulator.
`default_nettype none
module psc_datapath #(
  parameter int DELAY_DEPTH   = 4096,
  parameter int HISTORY_DEPTH = 256,
  parameter int PHASE_BITS    = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [psc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [psc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire psc_pkg::psc_cmd_t                 cmd,
  input  wire logic signed [15:0]                in_sample,
  output logic signed [15:0]                     out_sample
);
  import psc_pkg::*;

  localparam int PB   = PHASE_BITS;
  localparam int AW   = $clog2(DELAY_DEPTH);
  localparam int HW   = $clog2(HISTORY_DEPTH);
  localparam int RW   = PB + AW + 1;
  localparam int MA   = (PB + 1 > 34) ? PB + 1 : 34;
  localparam int PW   = MA + 18;
  localparam int ACCW = PW + 4;
  localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(32767) <<< 30;
  localparam logic signed [ACCW-1:0] SAT_LO = -(ACCW'(32768) <<< 30);

  // Configuration.
  logic signed [23:0] step_r;
  logic [11:0]        wlen_r;
  logic [7:0]         cdel_r;
  logic signed [15:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= -24'sd794;
      wlen_r <= 12'd2112;
      cdel_r <= 8'd144;
      gain_r <= 16'sd24576;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_STEP: step_r <= cfg_data;
        REG_WINDOW_LEN: wlen_r <= cfg_data[11:0];
        REG_COMB_DELAY: cdel_r <= cfg_data[7:0];
        REG_COMB_GAIN:  gain_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Clamped lengths.
  logic [11:0]   len_eff;
  logic [HW-1:0] cd_eff;
  always_comb begin
    if (wlen_r < 12'd10) begin
      len_eff = 12'd10;
    end else if (17'(wlen_r) >= 17'(DELAY_DEPTH)) begin
      len_eff = 12'(DELAY_DEPTH - 1);
    end else begin
      len_eff = wlen_r;
    end
    if (13'(cdel_r) >= 13'(HISTORY_DEPTH)) begin
      cd_eff = HW'(HISTORY_DEPTH - 1);
    end else begin
      cd_eff = HW'(cdel_r);
    end
  end

  // Pointers, phase, fill tracking.
  logic [AW-1:0] wp_r;
  logic [HW-1:0] hp_r;
  logic [PB-1:0] phase_r;
  logic          dfull_r, hfull_r;
  logic [31:0]   step_ext;

  assign step_ext = 32'(step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      hp_r    <= '0;
      phase_r <= '0;
      dfull_r <= 1'b0;
      hfull_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        phase_r <= phase_r + step_ext[PB-1:0];
      end
      if (cmd.finish) begin
        if (32'(wp_r) == DELAY_DEPTH - 1) begin
          wp_r    <= '0;
          dfull_r <= 1'b1;
        end else begin
          wp_r <= wp_r + 1'b1;
        end
        if (32'(hp_r) == HISTORY_DEPTH - 1) begin
          hp_r    <= '0;
          hfull_r <= 1'b1;
        end else begin
          hp_r <= hp_r + 1'b1;
        end
      end
    end
  end

  // Tap phase and window weight.
  logic [PB-1:0] ph_sel;
  logic [PB:0]   ph_neg;
  logic [16:0]   weight;
  assign ph_sel = cmd.tap2 ? (phase_r + {1'b1, {(PB-1){1'b0}}}) : phase_r;
  assign ph_neg = {1'b1, {PB{1'b0}}} - {1'b0, ph_sel};
  always_comb begin
    if (!ph_sel[PB-1]) begin
      weight = 17'(ph_sel >> (PB - 16));
    end else begin
      weight = 17'(ph_neg >> (PB - 16));
    end
  end

  // Shared multiplier.
  logic signed [PW-1:0] prod_r;
  logic signed [MA-1:0] ma;
  logic signed [17:0]   mb;
  logic signed [15:0]   a_r;
  logic signed [15:0]   b_val;
  logic signed [16:0]   diff;
  logic signed [33:0]   tap_r;
  logic [14:0]          frac_r;
  logic [16:0]          w_r;
  logic signed [15:0]   h_val;

  assign diff = 17'(b_val) - 17'(a_r);

  always_comb begin
    case (cmd.mul_op)
      MOP_DLY: begin
        ma = MA'(ph_sel);
        mb = {6'd0, len_eff};
      end
      MOP_FRAC: begin
        ma = MA'(diff);
        mb = {3'd0, frac_r};
      end
      MOP_WIN: begin
        ma = MA'(tap_r);
        mb = {1'b0, w_r};
      end
      MOP_COMB: begin
        ma = MA'(h_val);
        mb = 18'(gain_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end

  // Read address from delay product.
  logic [RW-1:0] wr_pos, d_pos, rd_pos;
  logic [AW-1:0] i0, i0_r, i1_r;
  assign wr_pos = RW'(wp_r) << PB;
  assign d_pos  = prod_r[RW-1:0];
  assign rd_pos = (d_pos > wr_pos) ? (wr_pos + (RW'(DELAY_DEPTH) << PB) - d_pos)
                                   : (wr_pos - d_pos);
  assign i0 = rd_pos[PB+AW-1:PB];

  always_ff @(posedge clk) begin
    if (cmd.addr_ld) begin
      i0_r   <= i0;
      i1_r   <= (32'(i0) == DELAY_DEPTH - 1) ? '0 : i0 + 1'b1;
      frac_r <= rd_pos[PB-1:PB-15];
      w_r    <= weight;
    end
  end

  // Delay memory; entries never written read as zero via the fill tracking.
  logic [15:0]   dmem [DELAY_DEPTH];
  logic [15:0]   drd_r;
  logic          dvld_r;
  logic [AW-1:0] draddr;
  assign draddr = cmd.rd_i0 ? i0_r : i1_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dmem[wp_r] <= in_sample;
    end
    if (cmd.rd_i0 || cmd.rd_i1) begin
      drd_r  <= dmem[draddr];
      dvld_r <= dfull_r || (draddr <= wp_r);
    end
  end

  assign b_val = dvld_r ? signed'(drd_r) : 16'sd0;

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      a_r <= b_val;
    end
    if (cmd.tap_ld) begin
      tap_r <= (34'(a_r) <<< 15) + 34'(prod_r);
    end
  end

  // History memory.
  logic [15:0]   hmem [HISTORY_DEPTH];
  logic [15:0]   hrd_r;
  logic          hvld_r;
  logic [HW:0]   hsub;
  logic [HW-1:0] hidx;
  logic signed [15:0] res;

  assign hsub = (cd_eff > hp_r) ? ({1'b0, hp_r} + (HW+1)'(HISTORY_DEPTH) - {1'b0, cd_eff})
                                : ({1'b0, hp_r} - {1'b0, cd_eff});
  assign hidx = hsub[HW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd_hist) begin
      hrd_r  <= hmem[hidx];
      hvld_r <= hfull_r || (hidx < hp_r);
    end
    if (cmd.finish) begin
      hmem[hp_r] <= res;
    end
  end

  assign h_val = hvld_r ? signed'(hrd_r) : 16'sd0;

  // Accumulator, saturation, truncation toward zero.
  logic signed [ACCW-1:0] acc_r, sat, quo;
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc_r <= '0;
    end else if (cmd.acc_tap) begin
      acc_r <= acc_r + ACCW'(prod_r);
    end else if (cmd.acc_comb) begin
      acc_r <= acc_r + (ACCW'(prod_r) <<< 15);
    end
  end

  always_comb begin
    if (acc_r > SAT_HI) begin
      sat = SAT_HI;
    end else if (acc_r < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = acc_r;
    end
    quo = sat >>> 30;
    if (sat[ACCW-1] && (sat[29:0] != 30'd0)) begin
      quo = quo + 1'b1;
    end
  end
  assign res = quo[15:0];

  logic signed [15:0] out_r;
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r <= res;
    end
  end
  assign out_sample = out_r;

endmodule
`default_nettype wire
